// ===== rtl/oahm_pkg.sv =====
package oahm_pkg;

	localparam int HASH_W = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 11;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_UNHASH    = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_GET = 2'd1
	} op_t;

	typedef enum logic [3:0] {
		FSM_CLR,
		FSM_IDLE,
		FSM_INIT,
		FSM_PRD,
		FSM_PCHK,
		FSM_GCHK,
		FSM_GCLR,
		FSM_GRD,
		FSM_GSRC,
		FSM_GINIT,
		FSM_GPRD,
		FSM_GPCHK,
		FSM_GNEXT,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic    load_item;
		logic    probe_init;
		logic    probe_step;
		logic    rd_src;
		logic    clr_all;
		logic    clr_grow;
		logic    sweep_rst;
		logic    wr_insert;
		logic    cnt_inc;
		logic    set_status;
		status_t status;
		logic    cap_value;
		logic    load_src;
		logic    src_rst;
		logic    src_inc;
		logic    grow_mode;
		logic    commit_grow;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic unhash;
		logic is_get;
		logic empty;
		logic match;
		logic exhausted;
		logic refuse;
		logic need_grow;
		logic all_last;
		logic grow_last;
		logic src_last;
		logic src_valid;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/open_addressing_hash_map_unit.sv =====
// Throughput: one item at a time; the next item is taken the cycle after its result is loaded.
// An insert that crosses the load threshold first clears the new bank (one slot a cycle), then
// moves the old bank, reading each old slot and re-probing each held key into the new bank.
// Reset: asynchronous, active low; then req_stall stays high while the whole memory is swept clear.
module open_addressing_hash_map_unit import oahm_pkg::*; #(
	parameter int KEY_W = 32,
	parameter int VALUE_W = 32,
	parameter int MIN_SIZE = 32,
	parameter int MAX_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [0:0]          op,
	input  logic [KEY_W-1:0]    key,
	input  logic [HASH_W-1:0]   key_hash,
	input  logic [VALUE_W-1:0]  value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [VALUE_W-1:0]  value_out,
	output logic [COUNT_W-1:0]  entry_count
);

	cmd_t cmd;
	sts_t sts;

	oahm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	oahm_dp #(
		.KEY_W    (KEY_W),
		.VALUE_W  (VALUE_W),
		.MIN_SIZE (MIN_SIZE),
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.key         (key),
		.key_hash    (key_hash),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.value_out   (value_out),
		.entry_count (entry_count),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ===== rtl/oahm_ram.sv =====
module oahm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/oahm_ctrl.sv =====
module oahm_ctrl import oahm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	fsm_t state_q, state_d;
	logic accept;

	assign req_stall = (state_q != FSM_IDLE);
	assign accept = req_valid && (state_q == FSM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLR: if (sts.all_last) state_d = FSM_IDLE;
			FSM_IDLE: if (accept) state_d = FSM_INIT;
			FSM_INIT: state_d = sts.unhash ? FSM_RESP : FSM_PRD;
			FSM_PRD: state_d = FSM_PCHK;
			FSM_PCHK: begin
				if (sts.empty) begin
					state_d = (sts.is_get || sts.refuse) ? FSM_RESP : FSM_GCHK;
				end else if (sts.match || sts.exhausted) begin
					state_d = FSM_RESP;
				end else begin
					state_d = FSM_PRD;
				end
			end
			FSM_GCHK: state_d = sts.need_grow ? FSM_GCLR : FSM_RESP;
			FSM_GCLR: if (sts.grow_last) state_d = FSM_GRD;
			FSM_GRD: state_d = FSM_GSRC;
			FSM_GSRC: begin
				if (sts.src_valid) begin
					state_d = FSM_GINIT;
				end else if (sts.src_last) begin
					state_d = FSM_RESP;
				end else begin
					state_d = FSM_GRD;
				end
			end
			FSM_GINIT: state_d = FSM_GPRD;
			FSM_GPRD: state_d = FSM_GPCHK;
			FSM_GPCHK: begin
				if (sts.empty || sts.match || sts.exhausted) begin
					state_d = FSM_GNEXT;
				end else begin
					state_d = FSM_GPRD;
				end
			end
			FSM_GNEXT: state_d = sts.src_last ? FSM_RESP : FSM_GRD;
			FSM_RESP: if (sts.out_free) state_d = FSM_IDLE;
			default: state_d = FSM_CLR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_INSERTED;
		case (state_q)
			FSM_CLR: cmd.clr_all = 1'b1;
			FSM_IDLE: cmd.load_item = accept;
			FSM_INIT: begin
				if (sts.unhash) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_UNHASH;
				end else begin
					cmd.probe_init = 1'b1;
				end
			end
			FSM_PCHK: begin
				if (sts.empty) begin
					cmd.set_status = 1'b1;
					if (sts.is_get) begin
						cmd.status = ST_NOT_FOUND;
					end else if (sts.refuse) begin
						cmd.status = ST_FULL;
					end else begin
						cmd.status = ST_INSERTED;
						cmd.wr_insert = 1'b1;
						cmd.cnt_inc = 1'b1;
					end
				end else if (sts.match) begin
					cmd.set_status = 1'b1;
					if (sts.is_get) begin
						cmd.status = ST_FOUND;
						cmd.cap_value = 1'b1;
					end else begin
						cmd.status = ST_REPLACED;
						cmd.wr_insert = 1'b1;
					end
				end else if (sts.exhausted) begin
					cmd.set_status = 1'b1;
					cmd.status = sts.is_get ? ST_NOT_FOUND : ST_FULL;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			FSM_GCHK: begin
				cmd.sweep_rst = 1'b1;
				cmd.src_rst = 1'b1;
			end
			FSM_GCLR: begin
				cmd.grow_mode = 1'b1;
				cmd.clr_grow = 1'b1;
			end
			FSM_GRD: begin
				cmd.grow_mode = 1'b1;
				cmd.rd_src = 1'b1;
			end
			FSM_GSRC: begin
				cmd.grow_mode = 1'b1;
				if (sts.src_valid) begin
					cmd.load_src = 1'b1;
				end else if (sts.src_last) begin
					cmd.commit_grow = 1'b1;
				end else begin
					cmd.src_inc = 1'b1;
				end
			end
			FSM_GINIT: begin
				cmd.grow_mode = 1'b1;
				cmd.probe_init = 1'b1;
			end
			FSM_GPRD: cmd.grow_mode = 1'b1;
			FSM_GPCHK: begin
				cmd.grow_mode = 1'b1;
				if (sts.empty || sts.match) begin
					cmd.wr_insert = 1'b1;
				end else if (!sts.exhausted) begin
					cmd.probe_step = 1'b1;
				end
			end
			FSM_GNEXT: begin
				cmd.grow_mode = 1'b1;
				if (sts.src_last) begin
					cmd.commit_grow = 1'b1;
				end else begin
					cmd.src_inc = 1'b1;
				end
			end
			FSM_RESP: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/oahm_dp.sv =====
module oahm_dp import oahm_pkg::*; #(
	parameter int KEY_W = 32,
	parameter int VALUE_W = 32,
	parameter int MIN_SIZE = 32,
	parameter int MAX_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [0:0]          op,
	input  logic [KEY_W-1:0]    key,
	input  logic [HASH_W-1:0]   key_hash,
	input  logic [VALUE_W-1:0]  value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [VALUE_W-1:0]  value_out,
	output logic [COUNT_W-1:0]  entry_count,
	input  cmd_t                cmd,
	output sts_t                sts
);

	localparam int MAX_LG = $clog2(MAX_SIZE + 1) - 1;
	localparam int MIN_LG = $clog2(MIN_SIZE + 1) - 1;
	localparam int INIT_LG = (MIN_LG < MAX_LG) ? MIN_LG : MAX_LG;
	localparam int IW = MAX_LG;
	localparam int AW = $clog2(2 * MAX_SIZE);
	localparam int LGW = $clog2(MAX_LG + 2);
	localparam int CW = IW + 2;
	localparam int DW = 1 + KEY_W + HASH_W + VALUE_W;

	logic [KEY_W-1:0]   key_q;
	logic [HASH_W-1:0]  hash_q;
	logic [VALUE_W-1:0] val_q;
	logic               get_q;
	logic [IW-1:0]      idx_q;
	logic [63:0]        pert_q;
	logic [CW-1:0]      pcnt_q;
	logic [LGW-1:0]     lg_q;
	logic               bank_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      swp_q;
	logic [IW-1:0]      src_q;
	status_t            stat_q;
	logic [VALUE_W-1:0] vout_q;
	logic               rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic [COUNT_W-1:0] rsp_count_q;

	logic [LGW-1:0]     plg;
	logic               pbank;
	logic [IW-1:0]      pmask, omask, nmask;
	logic [CW-1:0]      psize, osize, cnt1;
	logic [IW-1:0]      idx_next;
	logic [AW-1:0]      cur_base, new_base, probe_addr, src_addr, clr_addr;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [DW-1:0]      wdata, rdata;
	logic [KEY_W-1:0]   r_key;
	logic [HASH_W-1:0]  r_hash;
	logic [VALUE_W-1:0] r_val;
	logic               r_valid;
	logic               at_max;

	assign plg = cmd.grow_mode ? lg_q + LGW'(1) : lg_q;
	assign pbank = cmd.grow_mode ? ~bank_q : bank_q;
	assign pmask = ~({IW{1'b1}} << plg);
	assign omask = ~({IW{1'b1}} << lg_q);
	assign nmask = ~({IW{1'b1}} << (lg_q + LGW'(1)));
	assign psize = CW'(1) << plg;
	assign osize = CW'(1) << lg_q;
	assign cnt1 = cnt_q + CW'(1);
	assign idx_next = ((idx_q << 2) + idx_q + IW'(1) + pert_q[IW-1:0]) & pmask;

	assign cur_base = bank_q ? AW'(MAX_SIZE) : '0;
	assign new_base = bank_q ? '0 : AW'(MAX_SIZE);
	assign probe_addr = (pbank ? AW'(MAX_SIZE) : AW'(0)) + AW'(idx_q);
	assign src_addr = cur_base + AW'(src_q);
	assign clr_addr = cmd.clr_all ? swp_q : new_base + AW'(swp_q[IW-1:0]);

	assign we = cmd.clr_all || cmd.clr_grow || cmd.wr_insert;
	assign waddr = (cmd.clr_all || cmd.clr_grow) ? clr_addr : probe_addr;
	assign wdata = (cmd.clr_all || cmd.clr_grow) ? '0 : {1'b1, key_q, hash_q, val_q};
	assign raddr = cmd.rd_src ? src_addr : probe_addr;

	oahm_ram #(.WIDTH(DW), .DEPTH(2 * MAX_SIZE)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign {r_valid, r_key, r_hash, r_val} = rdata;
	assign at_max = (lg_q == LGW'(MAX_LG));

	always_comb begin
		sts.unhash = (hash_q == {HASH_W{1'b1}});
		sts.is_get = get_q;
		sts.empty = !r_valid;
		sts.match = r_valid && (r_key == key_q) && (r_hash == hash_q);
		sts.exhausted = (pcnt_q == psize + CW'(15));
		sts.refuse = at_max && ((osize < cnt1) || ((osize - cnt1) < (osize >> 2)));
		sts.need_grow = !at_max && ((osize < cnt_q) || ((osize - cnt_q) < (osize >> 2)));
		sts.all_last = (swp_q == AW'(2 * MAX_SIZE - 1));
		sts.grow_last = (swp_q[IW-1:0] == nmask);
		sts.src_last = (src_q == omask);
		sts.src_valid = r_valid;
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			get_q <= (op == 1'(OP_GET));
			key_q <= key;
			hash_q <= key_hash;
			val_q <= value;
			vout_q <= '0;
		end
		if (cmd.load_src) begin
			key_q <= r_key;
			hash_q <= r_hash;
			val_q <= r_val;
		end
		if (cmd.probe_init) begin
			idx_q <= hash_q[IW-1:0] & pmask;
			pert_q <= {{32{hash_q[HASH_W-1]}}, hash_q};
			pcnt_q <= '0;
		end else if (cmd.probe_step) begin
			idx_q <= idx_next;
			pert_q <= pert_q >> 5;
			pcnt_q <= pcnt_q + CW'(1);
		end
		if (cmd.set_status) begin
			stat_q <= cmd.status;
		end
		if (cmd.cap_value) begin
			vout_q <= r_val;
		end
		if (cmd.out_load) begin
			rsp_status_q <= stat_q;
			rsp_value_q <= vout_q;
			rsp_count_q <= COUNT_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LGW'(INIT_LG);
			bank_q <= 1'b0;
			cnt_q <= '0;
			swp_q <= '0;
			src_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt1;
			end
			if (cmd.sweep_rst) begin
				swp_q <= '0;
			end else if (cmd.clr_all || cmd.clr_grow) begin
				swp_q <= swp_q + AW'(1);
			end
			if (cmd.src_rst) begin
				src_q <= '0;
			end else if (cmd.src_inc) begin
				src_q <= src_q + IW'(1);
			end
			if (cmd.commit_grow) begin
				lg_q <= lg_q + LGW'(1);
				bank_q <= ~bank_q;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_status_q;
	assign value_out = rsp_value_q;
	assign entry_count = rsp_count_q;

endmodule

// ===== rtl/oahm_checker.sv =====
module oahm_props import oahm_pkg::*; #(
	parameter int VALUE_W = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [STATUS_W-1:0] status,
	input logic [VALUE_W-1:0]  value_out,
	input logic [COUNT_W-1:0]  entry_count
);

	logic [COUNT_W-1:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (rsp_valid && !rsp_stall) begin
			last_q <= entry_count;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count))
		else $error("result item changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == ST_INSERTED || status == ST_REPLACED ||
			status == ST_FOUND || status == ST_NOT_FOUND ||
			status == ST_UNHASH || status == ST_FULL)
		else $error("bad status code");

	a_vzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_FOUND |-> value_out == '0)
		else $error("value_out nonzero without a hit");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_INSERTED |-> entry_count == last_q)
		else $error("entry count moved without an insert");

endmodule

bind open_addressing_hash_map_unit oahm_props #(.VALUE_W(VALUE_W)) u_oahm_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.value_out   (value_out),
	.entry_count (entry_count)
);

// ===== verif/oahm_checker.sv =====
module oahm_checker import oahm_pkg::*; #(
	parameter int MIN_SIZE = 32,
	parameter int MAX_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [0:0]          op,
	input  logic [31:0]         key,
	input  logic [HASH_W-1:0]   key_hash,
	input  logic [31:0]         value,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [31:0]         value_out,
	input  logic [COUNT_W-1:0]  entry_count,
	output int                  fail_count,
	output int                  pending,
	output int                  n_full,
	output int                  n_grow
);

	typedef struct {
		status_t         st;
		logic [31:0]     val;
		logic [COUNT_W-1:0] cnt;
	} answer_t;

	bit          tbl_used [2*MAX_SIZE];
	logic [31:0] tbl_key  [2*MAX_SIZE];
	logic [31:0] tbl_hash [2*MAX_SIZE];
	logic [31:0] tbl_val  [2*MAX_SIZE];
	int          size_lg;
	int          bank;
	int          held;
	answer_t     answers [$];

	function automatic int lg2(int v);
		int r;
		r = 0;
		while (r < 31 && (1 << (r + 1)) <= v)
			r++;
		return r;
	endfunction

	// returns 1 match, 0 free, -1 exhausted
	function automatic int find_slot(int base, int lg, logic [31:0] k, logic [31:0] h,
			output int slot);
		logic [63:0] msk, pert, idx;
		int n, s;
		msk = (64'd1 << lg) - 1;
		pert = {{32{h[31]}}, h};
		idx = {32'd0, h} & msk;
		slot = 0;
		for (n = 0; n < (1 << lg) + 16; n++) begin
			s = base + int'(idx & msk);
			if (!tbl_used[s]) begin
				slot = s;
				return 0;
			end
			if (tbl_key[s] == k && tbl_hash[s] == h) begin
				slot = s;
				return 1;
			end
			idx = idx * 5 + 1 + pert;
			pert = pert >> 5;
		end
		return -1;
	endfunction

	task automatic rehash_double();
		int ob, nb, s, d;
		ob = bank * MAX_SIZE;
		nb = (bank ^ 1) * MAX_SIZE;
		for (s = 0; s < (1 << (size_lg + 1)); s++)
			tbl_used[nb + s] = 0;
		for (s = 0; s < (1 << size_lg); s++)
			if (tbl_used[ob + s] && find_slot(nb, size_lg + 1, tbl_key[ob + s],
					tbl_hash[ob + s], d) >= 0) begin
				tbl_used[d] = 1;
				tbl_key[d] = tbl_key[ob + s];
				tbl_hash[d] = tbl_hash[ob + s];
				tbl_val[d] = tbl_val[ob + s];
			end
		size_lg++;
		bank ^= 1;
		n_grow++;
	endtask

	task automatic predict_map(logic [0:0] o, logic [31:0] k, logic [31:0] h,
			logic [31:0] v);
		answer_t a;
		int base, sz, slot, r, max_lg;
		max_lg = lg2(MAX_SIZE);
		base = bank * MAX_SIZE;
		sz = 1 << size_lg;
		a.val = '0;
		if (h == 32'hFFFF_FFFF)
			a.st = ST_UNHASH;
		else if (o == OP_GET[0]) begin
			r = find_slot(base, size_lg, k, h, slot);
			if (r == 1) begin
				a.st = ST_FOUND;
				a.val = tbl_val[slot];
			end else
				a.st = ST_NOT_FOUND;
		end else begin
			r = find_slot(base, size_lg, k, h, slot);
			if (r == 1) begin
				tbl_val[slot] = v;
				a.st = ST_REPLACED;
			end else if (r < 0 || (size_lg >= max_lg &&
					(sz < held + 1 || sz - (held + 1) < (sz >> 2)))) begin
				a.st = ST_FULL;
				n_full++;
			end else begin
				tbl_used[slot] = 1;
				tbl_key[slot] = k;
				tbl_hash[slot] = h;
				tbl_val[slot] = v;
				held++;
				a.st = ST_INSERTED;
				if (size_lg < max_lg && (sz < held || sz - held < (sz >> 2)))
					rehash_double();
			end
		end
		a.cnt = COUNT_W'(held);
		answers.push_back(a);
	endtask

	initial begin
		int m, x;
		m = lg2(MIN_SIZE);
		x = lg2(MAX_SIZE);
		size_lg = (m < x) ? m : x;
		bank = 0;
		held = 0;
		fail_count = 0;
		pending = 0;
		n_full = 0;
		n_grow = 0;
		for (int i = 0; i < 2*MAX_SIZE; i++)
			tbl_used[i] = 0;
	end

	always @(posedge clk) begin
		answer_t a;
		if (arst_n) begin
			if (req_valid && !req_stall)
				predict_map(op, key, key_hash, value);
			if (rsp_valid && !rsp_stall) begin
				if (answers.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					a = answers.pop_front();
					if (status !== a.st) begin
						$error("status: expected %0d, got %0d", a.st, status);
						fail_count++;
					end
					if (value_out !== a.val) begin
						$error("value_out: expected %h, got %h", a.val, value_out);
						fail_count++;
					end
					if (entry_count !== a.cnt) begin
						$error("entry_count: expected %0d, got %0d", a.cnt, entry_count);
						fail_count++;
					end
				end
			end
			pending = answers.size();
		end
	end

endmodule

// ===== verif/tb_open_addressing_hash_map_unit.sv =====
module tb_open_addressing_hash_map_unit;
	import oahm_pkg::*;

	localparam int LIMIT = 2_000_000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                req_valid = 0;
	logic                req_stall;
	logic [0:0]          op = 0;
	logic [31:0]         key = 0;
	logic [HASH_W-1:0]   key_hash = 0;
	logic [31:0]         value = 0;
	logic                rsp_valid;
	logic                rsp_stall = 0;
	logic [STATUS_W-1:0] status;
	logic [31:0]         value_out;
	logic [COUNT_W-1:0]  entry_count;
	int                  fail_count, pending, n_full, n_grow;
	int                  cycles = 0;
	bit                  quiet = 0;
	bit                  hold_rsp = 0;
	int                  n_sent = 0;
	logic [31:0]         known_key [$];
	logic [31:0]         known_hash [$];

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	open_addressing_hash_map_unit dut (.*);

	oahm_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, plus a long hold when asked
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1;
				for (n = 0; n < 200; n++)
					@(posedge clk);
				hold_rsp = 0;
			end
			if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1;
				n = $urandom_range(1, 9);
			end else begin
				rsp_stall <= 0;
				n = $urandom_range(1, 12);
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send(logic [0:0] o, logic [31:0] k, logic [31:0] h, logic [31:0] v);
		req_valid <= 1;
		op <= o;
		key <= k;
		key_hash <= h;
		value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_item(int key_span);
		logic [31:0] k, h;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4) begin
			send($urandom_range(0, 1), $urandom, 32'hFFFF_FFFF, $urandom);
		end else if (sel < 45 && known_key.size() > 0) begin
			sel = $urandom_range(0, known_key.size() - 1);
			send($urandom_range(0, 1), known_key[sel], known_hash[sel], $urandom);
		end else begin
			k = $urandom_range(0, key_span);
			// narrow hashes force collisions; wide ones exercise every bit
			h = ($urandom_range(0, 1)) ? $urandom_range(0, 63) : $urandom;
			if (h == 32'hFFFF_FFFF)
				h = 0;
			if ($urandom_range(0, 2) == 0)
				send(OP_GET[0], k, h, $urandom);
			else begin
				send(OP_SET[0], k, h, $urandom);
				known_key.push_back(k);
				known_hash.push_back(h);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(OP_GET[0], 32'h0, 32'h0, 32'h0);
		send(OP_SET[0], 32'h0, 32'h0, 32'h0);
		send(OP_SET[0], 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send(OP_SET[0], 32'h8000_0000, 32'h8000_0000, 32'hA5A5_A5A5);
		send(OP_SET[0], 32'h1, 32'h0, 32'h1111_1111);
		send(OP_SET[0], 32'h0, 32'h1, 32'h2222_2222);
		send(OP_GET[0], 32'h0, 32'h0, 32'h0);
		send(OP_GET[0], 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		send(OP_GET[0], 32'h8000_0000, 32'h8000_0000, 32'h0);
		send(OP_GET[0], 32'h1, 32'h0, 32'h0);
		send(OP_GET[0], 32'h0, 32'h1, 32'h0);
		send(OP_SET[0], 32'h0, 32'h0, 32'h5555_5555);
		send(OP_GET[0], 32'h0, 32'h0, 32'h0);
		send(OP_SET[0], 32'h5, 32'hFFFF_FFFF, 32'h1);
		send(OP_GET[0], 32'h5, 32'hFFFF_FFFF, 32'h0);
		send(OP_GET[0], 32'h7, 32'hFFFF_FFFE, 32'h0);
		drain();
		// long receiver hold while items keep coming
		hold_rsp = 1;
		for (int i = 0; i < 20; i++)
			random_item(32'hFFFF_FFFF);
		drain();
		// random mix, the table goes through several doublings
		for (int i = 0; i < 1000; i++)
			random_item((i < 500) ? 300 : 32'hFFFF_FFFF);
		quiet = 1;
		for (int i = 0; i < 100; i++)
			random_item(32'hFFFF_FFFF);
		drain();
		$display("sent %0d items: %0d table doublings, %0d refused as full",
			n_sent, n_grow, n_full);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
